FILE: design/epd_pkg.sv
`default_nettype none

package epd_pkg;

    // Field widths of the stream items.
    localparam int unsigned LAT_W     = 31;
    localparam int unsigned LON_W     = 32;
    localparam int unsigned OUT_W     = 40;
    localparam int unsigned S_TDATA_W = 128;

    // Pi in Q2.30 and the scale from summed 1e-7 degree units to radians.
    localparam logic [31:0] PI_Q30    = 32'd3373259426;
    localparam logic [31:0] DEG_SCALE = 32'd3600000000;
    localparam logic [31:0] DEG_HALF  = 32'd1800000000;

    // Reciprocal of the degree scale, used for the first quotient estimate.
    localparam logic [127:0] PHI_RECIP_FULL = (128'd1 << 64) / 128'd3600000000;
    localparam logic [32:0]  PHI_RECIP      = PHI_RECIP_FULL[32:0];

    localparam logic [30:0] ONE_Q30 = 31'd1 << 30;

    // First eccentricity squared in Q40.
    localparam logic [63:0] E2_FULL = (64'd6694380023 << 30) / 64'd976562500;
    localparam logic [32:0] E2_Q40  = E2_FULL[32:0];

    // Radius constants in Q32 millimetres per 1e-7 degree.
    localparam logic [63:0] KA_FULL =
        (64'd637813700 * 64'd3373259426 * 64'd4 + 64'd90000000) / 64'd180000000;
    localparam logic [63:0] KM_FULL =
        (64'd633543933 * 64'd3373259426 * 64'd4 + 64'd90000000) / 64'd180000000;

    // Dividends of the two radius divisions.
    localparam logic [61:0] NUM_N = 62'(KA_FULL << 26);
    localparam logic [61:0] NUM_M = 62'(KM_FULL << 26);

    typedef logic signed [35:0] acc_t;
    typedef logic [32:0]        term_t;

    // Divisors of the sine and cosine series terms.
    function automatic int unsigned sin_div(input int unsigned k);
        return (2 * k) * (2 * k + 1);
    endfunction

    function automatic int unsigned cos_div(input int unsigned k);
        return (2 * k - 1) * (2 * k);
    endfunction

endpackage

`default_nettype wire

FILE: design/ellipsoid_plane_distance.sv
// Throughput: one item per cycle; the whole pipeline holds while m_tready is low
// and a result waits in the output register.
// Reset (aresetn low at a clock edge) clears all valid bits; the data registers
// keep their contents, and no result is lost or repeated across a stall.
`default_nettype none

module ellipsoid_plane_distance
    import epd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // first_lat[30:0], first_lon[62:31], second_lat[93:63], second_lon[125:94]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // distance_mm[39:0]
    output logic [OUT_W-1:0]          m_tdata
);

    // Stage numbers of the pipeline registers.
    localparam int unsigned ST_SC  = 24;
    localparam int unsigned ST_W3  = 60;
    localparam int unsigned ST_PRD = 93;
    localparam int unsigned LAT    = 147;

    logic adv;
    logic [LAT-1:0] vld_reg;

    // The pipeline moves whenever the output register is empty or being taken.
    assign adv      = ~vld_reg[LAT-1] | m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // Stage 0: sums and differences of the coordinates.
    logic [LAT_W-1:0] in_lat1, in_lat2;
    logic [LON_W-1:0] in_lon1, in_lon2;
    logic signed [31:0] lat_sum, lat_diff;
    logic signed [32:0] lon_diff;
    logic [31:0] sabs_next, sabs_reg;
    logic [31:0] dlat_next;
    logic [32:0] dlon_next;
    logic [31:0] dlat_line_reg [0:ST_PRD-1];
    logic [32:0] dlon_line_reg [0:ST_PRD];

    assign in_lat1 = s_tdata[30:0];
    assign in_lon1 = s_tdata[62:31];
    assign in_lat2 = s_tdata[93:63];
    assign in_lon2 = s_tdata[125:94];

    always_comb begin
        lat_sum   = {in_lat1[LAT_W-1], in_lat1} + {in_lat2[LAT_W-1], in_lat2};
        lat_diff  = {in_lat1[LAT_W-1], in_lat1} - {in_lat2[LAT_W-1], in_lat2};
        lon_diff  = {in_lon1[LON_W-1], in_lon1} - {in_lon2[LON_W-1], in_lon2};
        sabs_next = lat_sum[31] ? (~lat_sum + 32'd1) : lat_sum;
        dlat_next = lat_diff[31] ? (~lat_diff + 32'd1) : lat_diff;
        dlon_next = lon_diff[32] ? (~lon_diff + 33'd1) : lon_diff;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sabs_reg         <= sabs_next;
            dlat_line_reg[0] <= dlat_next;
            dlon_line_reg[0] <= dlon_next;
        end
    end

    // The coordinate differences ride along until the final products.
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 1; i < ST_PRD; i++) begin
                dlat_line_reg[i] <= dlat_line_reg[i-1];
            end
            for (int i = 1; i <= ST_PRD; i++) begin
                dlon_line_reg[i] <= dlon_line_reg[i-1];
            end
        end
    end

    // Stages 1 to 4: magnitude of the mean latitude in radians, rounded, by reciprocal division.
    logic [63:0] num_reg, num2_reg, num3_reg, prodq_reg;
    logic [64:0] qe_prod;
    logic [31:0] qe_reg, qe3_reg;
    logic [63:0] phi_rem;
    logic [31:0] phi_next, phi_reg;

    assign qe_prod = 65'(num_reg[63:32]) * 65'(PHI_RECIP);

    always_comb begin
        phi_rem  = num3_reg - prodq_reg;
        phi_next = qe3_reg
                 + 32'(phi_rem >= 64'(DEG_SCALE))
                 + 32'(phi_rem >= 64'(DEG_SCALE) * 64'd2)
                 + 32'(phi_rem >= 64'(DEG_SCALE) * 64'd3);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            num_reg   <= 64'(sabs_reg) * 64'(PI_Q30) + 64'(DEG_HALF);
            num2_reg  <= num_reg;
            qe_reg    <= qe_prod[63:32];
            num3_reg  <= num2_reg;
            qe3_reg   <= qe_reg;
            prodq_reg <= 64'(qe_reg) * 64'(DEG_SCALE);
            phi_reg   <= phi_next;
        end
    end

    // Stage 5: square of the angle for the series.
    logic [63:0] phi_sq;
    logic [31:0] x2_0_reg, phi_x_reg;

    assign phi_sq = 64'(phi_reg) * 64'(phi_reg) + (64'd1 << 29);

    always_ff @(posedge aclk) begin
        if (adv) begin
            x2_0_reg  <= phi_sq[61:30];
            phi_x_reg <= phi_reg;
        end
    end

    // Stages 6 to 23: one series term of sine and cosine per two stages.
    logic [62:0] pa_s_reg [1:9];
    logic [62:0] pa_c_reg [1:9];
    acc_t        acc_a_s_reg [1:9];
    acc_t        acc_a_c_reg [1:9];
    logic [31:0] x2a_reg [1:9];
    term_t       ts_reg [1:9];
    term_t       tc_reg [1:9];
    acc_t        acc_b_s_reg [1:9];
    acc_t        acc_b_c_reg [1:9];
    logic [31:0] x2b_reg [1:8];

    for (genvar k = 1; k <= 9; k++) begin : g_term
        localparam int unsigned CS = sin_div(k);
        localparam int unsigned CC = cos_div(k);
        localparam int unsigned KS = 33 + $clog2(CS);
        localparam int unsigned KC = 33 + $clog2(CC);
        localparam logic [34:0] MS = 35'(((68'd1 << KS) + 68'(CS) - 68'd1) / 68'(CS));
        localparam logic [34:0] MC = 35'(((68'd1 << KC) + 68'(CC) - 68'd1) / 68'(CC));

        term_t       ts_in, tc_in;
        acc_t        ss_in, cc_in;
        logic [31:0] x2_in;
        logic [64:0] ps_next, pc_next;
        logic [67:0] qs_prod, qc_prod;

        if (k == 1) begin : g_first
            assign ts_in = {1'b0, phi_x_reg};
            assign tc_in = 33'(ONE_Q30);
            assign ss_in = acc_t'({4'b0, phi_x_reg});
            assign cc_in = acc_t'({5'b0, ONE_Q30});
            assign x2_in = x2_0_reg;
        end else if (k % 2 == 0) begin : g_sub
            // The previous term has an odd index and is subtracted.
            assign ts_in = ts_reg[k-1];
            assign tc_in = tc_reg[k-1];
            assign ss_in = acc_b_s_reg[k-1] - acc_t'({3'b0, ts_reg[k-1]});
            assign cc_in = acc_b_c_reg[k-1] - acc_t'({3'b0, tc_reg[k-1]});
            assign x2_in = x2b_reg[k-1];
        end else begin : g_add
            assign ts_in = ts_reg[k-1];
            assign tc_in = tc_reg[k-1];
            assign ss_in = acc_b_s_reg[k-1] + acc_t'({3'b0, ts_reg[k-1]});
            assign cc_in = acc_b_c_reg[k-1] + acc_t'({3'b0, tc_reg[k-1]});
            assign x2_in = x2b_reg[k-1];
        end

        assign ps_next = 65'(ts_in) * 65'(x2_in);
        assign pc_next = 65'(tc_in) * 65'(x2_in);
        assign qs_prod = 68'(pa_s_reg[k][62:30]) * 68'(MS);
        assign qc_prod = 68'(pa_c_reg[k][62:30]) * 68'(MC);

        // Multiply by the angle square, then divide by the term's constant.
        always_ff @(posedge aclk) begin
            if (adv) begin
                pa_s_reg[k]    <= ps_next[62:0];
                pa_c_reg[k]    <= pc_next[62:0];
                acc_a_s_reg[k] <= ss_in;
                acc_a_c_reg[k] <= cc_in;
                x2a_reg[k]     <= x2_in;
                ts_reg[k]      <= 33'(qs_prod >> KS);
                tc_reg[k]      <= 33'(qc_prod >> KC);
                acc_b_s_reg[k] <= acc_a_s_reg[k];
                acc_b_c_reg[k] <= acc_a_c_reg[k];
            end
        end

        if (k < 9) begin : g_x2
            always_ff @(posedge aclk) begin
                if (adv) begin
                    x2b_reg[k] <= x2a_reg[k];
                end
            end
        end
    end

    // Stage 24: last term, magnitude and clamp to one.
    acc_t        ss_fin, cc_fin;
    logic [35:0] ss_mag, cc_mag;
    logic [30:0] sc_s_reg;
    logic [30:0] c_line_reg [ST_SC:ST_PRD-1];

    always_comb begin
        ss_fin = acc_b_s_reg[9] - acc_t'({3'b0, ts_reg[9]});
        cc_fin = acc_b_c_reg[9] - acc_t'({3'b0, tc_reg[9]});
        ss_mag = ss_fin[35] ? 36'(-ss_fin) : 36'(ss_fin);
        cc_mag = cc_fin[35] ? 36'(-cc_fin) : 36'(cc_fin);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sc_s_reg          <= (ss_mag > 36'(ONE_Q30)) ? ONE_Q30 : ss_mag[30:0];
            c_line_reg[ST_SC] <= (cc_mag > 36'(ONE_Q30)) ? ONE_Q30 : cc_mag[30:0];
            for (int i = ST_SC + 1; i < ST_PRD; i++) begin
                c_line_reg[i] <= c_line_reg[i-1];
            end
        end
    end

    // Stages 25 to 27: W squared in Q40.
    logic [61:0] s_sq;
    logic [30:0] s2_reg;
    logic [64:0] e_prod_reg, e_round;
    logic [40:0] w2_reg;

    assign s_sq    = 62'(sc_s_reg) * 62'(sc_s_reg) + (62'd1 << 29);
    assign e_round = e_prod_reg + (65'd1 << 29);

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_reg     <= s_sq[60:30];
            e_prod_reg <= 65'(E2_Q40) * 65'(s2_reg);
            w2_reg     <= (41'd1 << 40) - 41'(e_round >> 30);
        end
    end

    // Stages 28 to 59: square root of W squared, one root bit per stage.
    logic [63:0] rs_rem_reg  [0:31];
    logic [31:0] rs_root_reg [0:31];
    logic [40:0] rs_w2_reg   [0:31];

    for (genvar j = 0; j < 32; j++) begin : g_rs
        localparam int unsigned B = 31 - j;
        logic [63:0] rem_in, trial;
        logic [31:0] root_in;
        logic [40:0] w2_in;

        if (j == 0) begin : g_first
            assign rem_in  = {3'b0, w2_reg, 20'b0};
            assign root_in = '0;
            assign w2_in   = w2_reg;
        end else begin : g_next
            assign rem_in  = rs_rem_reg[j-1];
            assign root_in = rs_root_reg[j-1];
            assign w2_in   = rs_w2_reg[j-1];
        end

        assign trial = (64'(root_in) << (B + 1)) | (64'd1 << (2 * B));

        always_ff @(posedge aclk) begin
            if (adv) begin
                if (rem_in >= trial) begin
                    rs_rem_reg[j]  <= rem_in - trial;
                    rs_root_reg[j] <= root_in | (32'd1 << B);
                end else begin
                    rs_rem_reg[j]  <= rem_in;
                    rs_root_reg[j] <= root_in;
                end
                rs_w2_reg[j] <= w2_in;
            end
        end
    end

    // Stage 60: W cubed, and both divisors kept away from zero.
    logic [62:0] w3_prod;
    logic [30:0] w3_val, w_val;
    logic [30:0] w_div_reg, w3_div_reg;

    always_comb begin
        w3_prod = 63'(rs_root_reg[31]) * 63'(rs_w2_reg[31][40:10]);
        w3_val  = w3_prod[60:30];
        w_val   = rs_root_reg[31][30:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            w_div_reg  <= (w_val == '0) ? 31'd1 : w_val;
            w3_div_reg <= (w3_val == '0) ? 31'd1 : w3_val;
        end
    end

    // Stages 61 to 92: restoring division of the radius constants, one bit per stage.
    logic [30:0] dv_rn_reg [0:31];
    logic [30:0] dv_rm_reg [0:31];
    logic [31:0] dv_qn_reg [0:31];
    logic [31:0] dv_qm_reg [0:31];
    logic [30:0] dv_dn_reg [0:31];
    logic [30:0] dv_dm_reg [0:31];

    for (genvar j = 0; j < 32; j++) begin : g_dv
        logic [30:0] rn_in, rm_in, dn_in, dm_in;
        logic [31:0] qn_in, qm_in;
        logic [31:0] rn_sh, rm_sh;
        logic        n_ge, m_ge;

        if (j == 0) begin : g_first
            assign rn_in = 31'(NUM_N >> 32);
            assign rm_in = 31'(NUM_M >> 32);
            assign qn_in = '0;
            assign qm_in = '0;
            assign dn_in = w_div_reg;
            assign dm_in = w3_div_reg;
        end else begin : g_next
            assign rn_in = dv_rn_reg[j-1];
            assign rm_in = dv_rm_reg[j-1];
            assign qn_in = dv_qn_reg[j-1];
            assign qm_in = dv_qm_reg[j-1];
            assign dn_in = dv_dn_reg[j-1];
            assign dm_in = dv_dm_reg[j-1];
        end

        assign rn_sh = {rn_in, NUM_N[31-j]};
        assign rm_sh = {rm_in, NUM_M[31-j]};
        assign n_ge  = rn_sh >= {1'b0, dn_in};
        assign m_ge  = rm_sh >= {1'b0, dm_in};

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_rn_reg[j] <= n_ge ? 31'(rn_sh - {1'b0, dn_in}) : rn_sh[30:0];
                dv_rm_reg[j] <= m_ge ? 31'(rm_sh - {1'b0, dm_in}) : rm_sh[30:0];
                dv_qn_reg[j] <= {qn_in[30:0], n_ge};
                dv_qm_reg[j] <= {qm_in[30:0], m_ge};
                dv_dn_reg[j] <= dn_in;
                dv_dm_reg[j] <= dm_in;
            end
        end
    end

    // Stages 93 to 95: the two legs in Q8 millimetres, then their partial squares.
    logic [62:0] nc_prod;
    logic [32:0] nc_reg;
    logic [63:0] t1p_reg;
    logic [65:0] t2p_reg;
    logic [43:0] t1_reg, t2_val;
    logic [43:0] pp1_hh_reg, pp1_hl_reg, pp1_ll_reg;
    logic [43:0] pp2_hh_reg, pp2_hl_reg, pp2_ll_reg;

    assign nc_prod = 63'(dv_qn_reg[31]) * 63'(c_line_reg[ST_PRD-1]);
    assign t2_val  = t2p_reg[63:20];

    always_ff @(posedge aclk) begin
        if (adv) begin
            nc_reg     <= nc_prod[62:30];
            t1p_reg    <= 64'(dv_qm_reg[31]) * 64'(dlat_line_reg[ST_PRD-1]);
            t2p_reg    <= 66'(nc_reg) * 66'(dlon_line_reg[ST_PRD]);
            t1_reg     <= t1p_reg[63:20];
            pp1_hh_reg <= 44'(t1_reg[43:22]) * 44'(t1_reg[43:22]);
            pp1_hl_reg <= 44'(t1_reg[43:22]) * 44'(t1_reg[21:0]);
            pp1_ll_reg <= 44'(t1_reg[21:0]) * 44'(t1_reg[21:0]);
            pp2_hh_reg <= 44'(t2_val[43:22]) * 44'(t2_val[43:22]);
            pp2_hl_reg <= 44'(t2_val[43:22]) * 44'(t2_val[21:0]);
            pp2_ll_reg <= 44'(t2_val[21:0]) * 44'(t2_val[21:0]);
        end
    end

    // Stage 96: sum of both squares.
    logic [88:0] sq_sum_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_sum_reg <= (89'(pp1_hh_reg) << 44) + (89'(pp1_hl_reg) << 23)
                        + 89'(pp1_ll_reg)
                        + (89'(pp2_hh_reg) << 44) + (89'(pp2_hl_reg) << 23)
                        + 89'(pp2_ll_reg);
        end
    end

    // Stages 97 to 145: square root of the sum, one root bit per stage.
    logic [97:0] rq_rem_reg  [0:48];
    logic [48:0] rq_root_reg [0:48];

    for (genvar j = 0; j < 49; j++) begin : g_rq
        localparam int unsigned B = 48 - j;
        logic [97:0] rem_in, trial;
        logic [48:0] root_in;

        if (j == 0) begin : g_first
            assign rem_in  = 98'(sq_sum_reg);
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = rq_rem_reg[j-1];
            assign root_in = rq_root_reg[j-1];
        end

        assign trial = (98'(root_in) << (B + 1)) | (98'd1 << (2 * B));

        always_ff @(posedge aclk) begin
            if (adv) begin
                if (rem_in >= trial) begin
                    rq_rem_reg[j]  <= rem_in - trial;
                    rq_root_reg[j] <= root_in | (49'd1 << B);
                end else begin
                    rq_rem_reg[j]  <= rem_in;
                    rq_root_reg[j] <= root_in;
                end
            end
        end
    end

    // Stage 146: round Q8 to millimetres and saturate.
    logic [49:0] dist_round;
    logic [OUT_W-1:0] dist_reg;

    assign dist_round = 50'(rq_root_reg[48]) + 50'd128;

    always_ff @(posedge aclk) begin
        if (adv) begin
            dist_reg <= ((dist_round >> 8) > 50'({OUT_W{1'b1}})) ?
                        {OUT_W{1'b1}} : dist_round[OUT_W+7:8];
        end
    end

    assign m_tdata = dist_reg;

    // A waiting result holds the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while the result is stalled");

    // Sine and cosine never exceed one after the clamp.
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_SC] |-> (sc_s_reg <= ONE_Q30 && c_line_reg[ST_SC] <= ONE_Q30))
        else $error("sine or cosine above one");

    // Both divisors are nonzero when they enter the divider.
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_W3] |-> (w_div_reg != '0 && w3_div_reg != '0))
        else $error("zero divisor in radius division");

endmodule

`default_nettype wire
